FILE: hw/rtl/rtss_pkg.sv
// Shared types and constants of the right triangle side solver.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rtss_pkg;

    // Default side width; the Q16.16 format keeps its fraction bits through the
    // square root, so the fraction position needs no logic of its own.
    localparam int DEFAULT_SIDE_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_LEG_A   = 2'd0,
        OP_LEG_B   = 2'd1,
        OP_HYP     = 2'd2,
        OP_INVALID = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT_HYP = 2'd1,
        STATUS_BAD_MODE  = 2'd2
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rtss_if.sv
// Valid/ready channel interfaces of the right triangle side solver.
// Depends on rtss_pkg for the operation and status types.
`default_nettype none

interface rtss_in_if
    import rtss_pkg::*;
#(
    parameter int SIDE_WIDTH = DEFAULT_SIDE_WIDTH
);
    logic                  valid;
    logic                  ready;
    op_t                   operation;
    logic [SIDE_WIDTH-1:0] first_side;
    logic [SIDE_WIDTH-1:0] second_side;

    modport source (output valid, output operation, output first_side,
                    output second_side, input ready);
    modport sink   (input valid, input operation, input first_side,
                    input second_side, output ready);
endinterface

interface rtss_out_if
    import rtss_pkg::*;
#(
    parameter int SIDE_WIDTH = DEFAULT_SIDE_WIDTH
);
    logic                valid;
    logic                ready;
    logic [SIDE_WIDTH:0] side_value;
    status_t             status;

    modport source (output valid, output side_value, output status, input ready);
    modport sink   (input valid, input side_value, input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/right_triangle_side_solver.sv
// Right triangle side solver: squares, radicand and a bit-per-stage square root.
// Depends on rtss_pkg and the channel interfaces in rtss_if.sv.
//
// Usage:
//   req carries one transaction per item: operation, first_side, second_side
//   (unsigned fixed point). Operations 0 and 1 solve a leg from the known leg
//   (first_side) and the hypotenuse (second_side); operation 2 solves the
//   hypotenuse from both legs; operation 3 is rejected with status 2.
//   rsp carries one transaction per item: side_value (one integer bit wider
//   than the sides, truncated) and status. A hypotenuse shorter than the leg
//   gives status 1. side_value is zero whenever status is not 0.
//   The pipeline registers the partial products, then the sum of the squares,
//   then the radicand, then one result bit per stage in the square root
//   pipeline, whose last stage is the output register. Throughput is one
//   transaction per cycle while rsp is not stalled.
//   When rsp is stalled the whole pipeline holds and req.ready drops in the
//   same cycle; nothing is lost or repeated. Reset clears all valid bits,
//   so the block comes up empty and ready.
`default_nettype none

module right_triangle_side_solver
    import rtss_pkg::*;
#(
    parameter int SIDE_WIDTH = DEFAULT_SIDE_WIDTH
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rtss_in_if.sink      req,
    rtss_out_if.source   rsp
);

    localparam int LO_W   = (SIDE_WIDTH + 1) / 2;
    localparam int HI_W   = SIDE_WIDTH - LO_W;
    localparam int SQ_W   = 2 * SIDE_WIDTH;
    localparam int RAD_W  = 2 * SIDE_WIDTH + 1;
    localparam int ROOT_W = SIDE_WIDTH + 1;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic adv;

    // ---------------- stage 1: partial products and status ----------------
    logic                   p1_valid_reg;
    logic [2*LO_W-1:0]      ll1_reg, ll2_reg, ll1_next, ll2_next;
    logic [SIDE_WIDTH-1:0]  lh1_reg, lh2_reg, lh1_next, lh2_next;
    logic [2*HI_W-1:0]      hh1_reg, hh2_reg, hh1_next, hh2_next;
    logic                   p1_hyp_reg, p1_hyp_next;
    status_t                p1_status_reg, p1_status_next;

    always_comb
    begin
        ll1_next = (2*LO_W)'(req.first_side[LO_W-1:0])
                 * (2*LO_W)'(req.first_side[LO_W-1:0]);
        lh1_next = SIDE_WIDTH'(req.first_side[LO_W-1:0])
                 * SIDE_WIDTH'(req.first_side[SIDE_WIDTH-1:LO_W]);
        hh1_next = (2*HI_W)'(req.first_side[SIDE_WIDTH-1:LO_W])
                 * (2*HI_W)'(req.first_side[SIDE_WIDTH-1:LO_W]);
        ll2_next = (2*LO_W)'(req.second_side[LO_W-1:0])
                 * (2*LO_W)'(req.second_side[LO_W-1:0]);
        lh2_next = SIDE_WIDTH'(req.second_side[LO_W-1:0])
                 * SIDE_WIDTH'(req.second_side[SIDE_WIDTH-1:LO_W]);
        hh2_next = (2*HI_W)'(req.second_side[SIDE_WIDTH-1:LO_W])
                 * (2*HI_W)'(req.second_side[SIDE_WIDTH-1:LO_W]);
        p1_hyp_next = (req.operation == OP_HYP);
        case (req.operation)
            OP_INVALID: p1_status_next = STATUS_BAD_MODE;
            OP_HYP:     p1_status_next = STATUS_OK;
            default:    p1_status_next = (req.second_side < req.first_side)
                                         ? STATUS_SHORT_HYP : STATUS_OK;
        endcase
    end

    // ---------------- stage 2: full squares ----------------
    logic              p2_valid_reg;
    logic [SQ_W-1:0]   sq1_reg, sq2_reg, sq1_next, sq2_next;
    logic              p2_hyp_reg;
    status_t           p2_status_reg;

    // x^2 = hi^2 * 2^(2L) + 2*lo*hi * 2^L + lo^2
    always_comb
    begin
        sq1_next = (SQ_W'(hh1_reg) << (2*LO_W)) + (SQ_W'(lh1_reg) << (LO_W+1))
                 + SQ_W'(ll1_reg);
        sq2_next = (SQ_W'(hh2_reg) << (2*LO_W)) + (SQ_W'(lh2_reg) << (LO_W+1))
                 + SQ_W'(ll2_reg);
    end

    // ---------------- stage 3: radicand, then square root stages ----------------
    logic                v_reg      [ROOT_W+1];
    logic [PAD_W-1:0]    rad_reg    [ROOT_W+1];
    logic [REM_W-1:0]    rem_reg    [ROOT_W+1];
    logic [ROOT_W-1:0]   root_reg   [ROOT_W+1];
    status_t             status_reg [ROOT_W+1];
    logic [RAD_W-1:0]    rad_next;

    // Errors feed a zero radicand so the root comes out zero.
    always_comb
    begin
        if (p2_status_reg != STATUS_OK)
        begin
            rad_next = '0;
        end
        else if (p2_hyp_reg)
        begin
            rad_next = RAD_W'(sq1_reg) + RAD_W'(sq2_reg);
        end
        else
        begin
            rad_next = RAD_W'(sq2_reg - sq1_reg);
        end
    end

    assign adv       = !v_reg[ROOT_W] || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            v_reg[0]     <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= req.valid;
            p2_valid_reg <= p1_valid_reg;
            v_reg[0]     <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ll1_reg       <= ll1_next;
            lh1_reg       <= lh1_next;
            hh1_reg       <= hh1_next;
            ll2_reg       <= ll2_next;
            lh2_reg       <= lh2_next;
            hh2_reg       <= hh2_next;
            p1_hyp_reg    <= p1_hyp_next;
            p1_status_reg <= p1_status_next;
            sq1_reg       <= sq1_next;
            sq2_reg       <= sq2_next;
            p2_hyp_reg    <= p1_hyp_reg;
            p2_status_reg <= p1_status_reg;
            rad_reg[0]    <= PAD_W'(rad_next);
            rem_reg[0]    <= '0;
            root_reg[0]   <= '0;
            status_reg[0] <= p2_status_reg;
        end
    end

    // One result bit per stage: bring down two radicand bits, try root*4+1.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            rem_sh = {rem_reg[k][REM_W-3:0], rad_reg[k][PAD_W-1 -: 2]};
            trial  = {root_reg[k], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[k+1]    <= {rad_reg[k][PAD_W-3:0], 2'b00};
                rem_reg[k+1]    <= rem_next;
                root_reg[k+1]   <= root_next;
                status_reg[k+1] <= status_reg[k];
            end
        end
    end

    assign rsp.valid      = v_reg[ROOT_W];
    assign rsp.side_value = root_reg[ROOT_W];
    assign rsp.status     = status_reg[ROOT_W];

    // ---------------- assertions ----------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != STATUS_OK |-> rsp.side_value == '0)
        else $error("nonzero side_value on an error result");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ({1'b0, rem_reg[ROOT_W]} <= {2'b00, root_reg[ROOT_W], 1'b0}))
        else $error("square root remainder exceeds twice the root");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg[0]) && $stable(p1_valid_reg) && $stable(p2_valid_reg))
        else $error("pipeline valid bits moved during a stall");

    a_bad_mode: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg && p2_status_reg == STATUS_OK && !p2_hyp_reg
        |-> sq2_reg >= sq1_reg)
        else $error("leg radicand would go negative without a status");

endmodule

`default_nettype wire
